/* hdl/indexed_double_ended_list_defines.svh */
// assertion macros shared by the checker of the indexed double-ended list
// no dependencies; expects signals named clock and reset in the using scope
`ifndef INDEXED_DOUBLE_ENDED_LIST_DEFINES_SVH
`define INDEXED_DOUBLE_ENDED_LIST_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define IDEL_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// implication checked in the cycle after the condition
`define IDEL_ASSERT_NEXT(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error(msg);

`endif

/* hdl/idel_pkg.sv */
// types, constants and codes for the indexed double-ended list
// no dependencies; imported by every module of the block
package idel_pkg;

   localparam int CAPACITY      = 16;
   localparam int IDX_W         = $clog2(CAPACITY);
   localparam int CNT_W         = $clog2(CAPACITY + 1);
   localparam int VALUE_W       = 32;
   localparam int POS_W         = 8;
   localparam int CMP_W         = POS_W + 1;
   localparam int ENTRY_COUNT_W = 5;

   localparam logic [VALUE_W-1:0] MIN_VALUE = {1'b1, {(VALUE_W-1){1'b0}}};

   // request codes
   localparam logic [2:0] REQ_INS_TAIL = 3'd0;
   localparam logic [2:0] REQ_INS_HEAD = 3'd1;
   localparam logic [2:0] REQ_DEL_POS  = 3'd2;
   localparam logic [2:0] REQ_DEL_HEAD = 3'd3;
   localparam logic [2:0] REQ_DEL_TAIL = 3'd4;
   localparam logic [2:0] REQ_READ     = 3'd5;

   // status codes
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_BAD_INDEX = 2'd1;
   localparam logic [1:0] STATUS_FULL      = 2'd2;
   localparam logic [1:0] STATUS_EMPTY     = 2'd3;

   // read index select
   localparam logic [1:0] RD_POS  = 2'd0;
   localparam logic [1:0] RD_HEAD = 2'd1;
   localparam logic [1:0] RD_TAIL = 2'd2;

   // response value select
   localparam logic [1:0] VAL_ZERO = 2'd0;
   localparam logic [1:0] VAL_READ = 2'd1;
   localparam logic [1:0] VAL_MIN  = 2'd2;

   typedef struct packed {
      logic [2:0]                req_type;
      logic signed [VALUE_W-1:0] item_value;
      logic [POS_W-1:0]          position;
   } idel_request_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] read_value;
      logic [1:0]                status;
      logic [ENTRY_COUNT_W-1:0]  entry_count;
      logic                      list_empty;
   } idel_response_type;

   typedef struct packed {
      logic       load;
      logic       exec;
      logic       ins_head;
      logic       ins_tail;
      logic       remove;
      logic [1:0] rd_sel;
      logic [1:0] val_sel;
      logic [1:0] status;
   } idel_cmd_type;

   typedef struct packed {
      logic [2:0] req_kind;
      logic       full;
      logic       empty;
      logic       pos_ok;
   } idel_stat_type;

endpackage

/* hdl/indexed_double_ended_list.sv */
// indexed double-ended list: top level joining controller and datapath
// request registered when accepted; the execute state then registers response and strobe
// no new request is accepted during the single execute state of the controller
// a new request may be transferred while the previous response is on the output
// reset: synchronous, active high; clears count and control, entry cells are left as they are
// depends on idel_pkg, idel_ctrl and idel_datapath
module indexed_double_ended_list import idel_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  idel_request_type  req_data,
   output logic              rsp_strobe,
   output idel_response_type rsp_data
);

   idel_cmd_type  cmd;
   idel_stat_type stat;

   idel_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .stat       (stat),
      .cmd        (cmd),
      .busy       (busy),
      .rsp_strobe (rsp_strobe)
   );

   idel_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

/* hdl/idel_datapath.sv */
// entry cells, count, request and response registers of the list
// depends on idel_pkg; driven by commands from idel_ctrl
module idel_datapath import idel_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  idel_request_type  req_data,
   input  idel_cmd_type      cmd,
   output idel_stat_type     stat,
   output idel_response_type rsp_data
);

   idel_request_type          req_ff;
   logic [VALUE_W-1:0]        cells_ff [CAPACITY];
   logic [VALUE_W-1:0]        cells_in [CAPACITY];
   logic [CNT_W-1:0]          count_ff;
   logic [CNT_W-1:0]          count_in;
   idel_response_type         rsp_ff;
   idel_response_type         rsp_in;
   logic [IDX_W-1:0]          rd_idx;
   logic [VALUE_W-1:0]        rd_value;

   assign stat.req_kind = req_ff.req_type;
   assign stat.full     = (count_ff == CNT_W'(CAPACITY));
   assign stat.empty    = (count_ff == '0);
   assign stat.pos_ok   = (CMP_W'(req_ff.position) < CMP_W'(count_ff));

   always_comb begin
      unique case (cmd.rd_sel)
         RD_POS:  rd_idx = req_ff.position[IDX_W-1:0];
         RD_HEAD: rd_idx = '0;
         RD_TAIL: rd_idx = IDX_W'(count_ff - CNT_W'(1));
         default: rd_idx = '0;
      endcase
   end

   assign rd_value = cells_ff[rd_idx];

   // cell chain: a head insert shifts right, a tail insert writes at the count, a removal closes the gap from rd_idx up
   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_in[i] = cells_ff[i];
      end
      count_in = count_ff;
      if (cmd.exec) begin
         if (cmd.ins_head) begin
            cells_in[0] = req_ff.item_value;
            for (int i = 1; i < CAPACITY; i++) begin
               cells_in[i] = cells_ff[i-1];
            end
            count_in = count_ff + CNT_W'(1);
         end else if (cmd.ins_tail) begin
            cells_in[count_ff[IDX_W-1:0]] = req_ff.item_value;
            count_in = count_ff + CNT_W'(1);
         end else if (cmd.remove) begin
            for (int i = 0; i < CAPACITY - 1; i++) begin
               if (IDX_W'(i) >= rd_idx) begin
                  cells_in[i] = cells_ff[i+1];
               end
            end
            count_in = count_ff - CNT_W'(1);
         end
      end
   end

   always_comb begin
      case (cmd.val_sel)
         VAL_READ: rsp_in.read_value = rd_value;
         VAL_MIN:  rsp_in.read_value = MIN_VALUE;
         default:  rsp_in.read_value = '0;
      endcase
      rsp_in.status      = cmd.status;
      rsp_in.entry_count = count_in[ENTRY_COUNT_W-1:0];
      rsp_in.list_empty  = (count_in == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < CAPACITY; i++) begin
         cells_ff[i] <= cells_in[i];
      end
      if (cmd.load) begin
         req_ff <= req_data;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

/* hdl/idel_ctrl.sv */
// controller of the list: request sequencing and per-request decode
// depends on idel_pkg; commands idel_datapath from its status
module idel_ctrl import idel_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  idel_stat_type stat,
   output idel_cmd_type  cmd,
   output logic          busy,
   output logic          rsp_strobe
);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_EXEC = 1'b1;

   logic state_ff;
   logic state_in;
   logic strobe_ff;
   logic strobe_in;

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec  = 1'b1;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
            unique case (stat.req_kind) inside
               REQ_INS_TAIL, REQ_INS_HEAD: begin
                  if (stat.full) begin
                     cmd.status = STATUS_FULL;
                  end else begin
                     cmd.ins_tail = (stat.req_kind == REQ_INS_TAIL);
                     cmd.ins_head = (stat.req_kind == REQ_INS_HEAD);
                  end
               end
               REQ_DEL_POS, REQ_READ: begin
                  cmd.rd_sel = RD_POS;
                  if (stat.pos_ok) begin
                     cmd.val_sel = VAL_READ;
                     cmd.remove  = (stat.req_kind == REQ_DEL_POS);
                  end else begin
                     cmd.val_sel = VAL_MIN;
                     cmd.status  = STATUS_BAD_INDEX;
                  end
               end
               REQ_DEL_HEAD, REQ_DEL_TAIL: begin
                  cmd.rd_sel = (stat.req_kind == REQ_DEL_HEAD) ? RD_HEAD : RD_TAIL;
                  if (stat.empty) begin
                     cmd.val_sel = VAL_MIN;
                     cmd.status  = STATUS_EMPTY;
                  end else begin
                     cmd.val_sel = VAL_READ;
                     cmd.remove  = 1'b1;
                  end
               end
               default: begin
                  // unused codes give a zero ok response
               end
            endcase
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   assign busy       = (state_ff == S_EXEC);
   assign rsp_strobe = strobe_ff;

endmodule

/* hdl/idel_checker.sv */
// port-level checks of the indexed double-ended list, bound to the top level
// depends on idel_pkg and indexed_double_ended_list_defines.svh
`include "indexed_double_ended_list_defines.svh"

module idel_checker import idel_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input idel_response_type rsp_data
);

   logic accept;
   logic empty_flag_ok;
   logic full_count_ok;
   logic bad_index_ok;

   assign accept        = start && !busy;
   assign empty_flag_ok = (rsp_data.list_empty == (rsp_data.entry_count == '0));
   assign full_count_ok = (rsp_data.status != STATUS_FULL) ||
                          (rsp_data.entry_count == ENTRY_COUNT_W'(CAPACITY));
   assign bad_index_ok  = (rsp_data.status != STATUS_BAD_INDEX) ||
                          (rsp_data.read_value == MIN_VALUE);

   `IDEL_ASSERT_NEXT(a_accept_busy, accept, busy && !rsp_strobe, "request did not go busy")
   `IDEL_ASSERT_NEXT(a_busy_strobe, busy, rsp_strobe && !busy, "no response after execute")
   `IDEL_ASSERT(a_empty_flag, !rsp_strobe || empty_flag_ok, "empty flag disagrees with count")
   `IDEL_ASSERT(a_full_count, !rsp_strobe || full_count_ok, "full status with list not full")
   `IDEL_ASSERT(a_bad_index_min, !rsp_strobe || bad_index_ok, "bad index without minimum value")

endmodule

bind indexed_double_ended_list idel_checker u_idel_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

/* tb/indexed_double_ended_list_tb.sv */
// self-checking testbench for the indexed double-ended list: directed corner cases, then
// random request mixes, with responses checked against an in-bench list tracker
// depends on idel_pkg and indexed_double_ended_list
module indexed_double_ended_list_tb import idel_pkg::*; ();

   localparam int RANDOM_ITEMS = 1430;
   localparam int QUIET_ITEMS  = 150;
   localparam int MIX_SPAN     = 48;
   localparam int CYCLE_LIMIT  = 200000;
   localparam logic signed [VALUE_W-1:0] MAX_VALUE = {1'b0, {(VALUE_W-1){1'b1}}};

   typedef enum int {FILL_UP, DRAIN, CHURN} list_mix_type;

   class idel_scoreboard_type;
      logic signed [VALUE_W-1:0] held_values [CAPACITY];
      int unsigned               held_count;
      idel_response_type         expected_responses [$];
      int unsigned               mismatches;
      int unsigned               requests_seen;
      int unsigned               responses_checked;
      int unsigned               full_rejects;
      int unsigned               bad_positions;
      int unsigned               empty_removes;

      function new();
         held_count        = 0;
         mismatches        = 0;
         requests_seen     = 0;
         responses_checked = 0;
         full_rejects      = 0;
         bad_positions     = 0;
         empty_removes     = 0;
      endfunction

      function int pending();
         return expected_responses.size();
      endfunction

      // close the gap left at pos
      function void remove_at(int unsigned pos);
         for (int unsigned k = pos; k + 1 < held_count; k++) held_values[k] = held_values[k+1];
         held_count--;
      endfunction

      function void note_request(idel_request_type r);
         idel_response_type rsp;
         rsp.read_value = '0;
         rsp.status     = STATUS_OK;
         requests_seen++;
         case (r.req_type) inside
            REQ_INS_TAIL, REQ_INS_HEAD: begin
               if (held_count >= CAPACITY) begin
                  rsp.status = STATUS_FULL;
                  full_rejects++;
               end else if (r.req_type == REQ_INS_HEAD) begin
                  for (int unsigned k = held_count; k > 0; k--) held_values[k] = held_values[k-1];
                  held_values[0] = r.item_value;
                  held_count++;
               end else begin
                  held_values[held_count] = r.item_value;
                  held_count++;
               end
            end
            REQ_DEL_POS, REQ_READ: begin
               if (r.position >= held_count) begin
                  rsp.status     = STATUS_BAD_INDEX;
                  rsp.read_value = MIN_VALUE;
                  bad_positions++;
               end else begin
                  rsp.read_value = held_values[r.position];
                  if (r.req_type == REQ_DEL_POS) remove_at(r.position);
               end
            end
            REQ_DEL_HEAD, REQ_DEL_TAIL: begin
               if (held_count == 0) begin
                  rsp.status     = STATUS_EMPTY;
                  rsp.read_value = MIN_VALUE;
                  empty_removes++;
               end else if (r.req_type == REQ_DEL_HEAD) begin
                  rsp.read_value = held_values[0];
                  remove_at(0);
               end else begin
                  rsp.read_value = held_values[held_count-1];
                  held_count--;
               end
            end
            default: begin
               // unused codes leave the list alone
            end
         endcase
         rsp.entry_count = ENTRY_COUNT_W'(held_count);
         rsp.list_empty  = (held_count == 0);
         expected_responses.push_back(rsp);
      endfunction

      function void compare_field(string name, logic [VALUE_W-1:0] e, logic [VALUE_W-1:0] a);
         if (a !== e) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
            mismatches++;
         end
      endfunction

      function void check_response(idel_response_type got);
         idel_response_type exp;
         if (expected_responses.size() == 0) begin
            $display("%0t: response with nothing expected, expected none, actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         exp = expected_responses.pop_front();
         responses_checked++;
         compare_field("read_value", exp.read_value, got.read_value);
         compare_field("status", VALUE_W'(exp.status), VALUE_W'(got.status));
         compare_field("entry_count", VALUE_W'(exp.entry_count), VALUE_W'(got.entry_count));
         compare_field("list_empty", VALUE_W'(exp.list_empty), VALUE_W'(got.list_empty));
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   idel_request_type    req_data = '0;
   logic                rsp_strobe;
   idel_response_type   rsp_data;
   int unsigned         cycle_count = 0;
   idel_scoreboard_type board = new();

   indexed_double_ended_list i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) board.check_response(rsp_data);
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("timed out after %0d cycles with %0d responses outstanding",
               cycle_count, board.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   function automatic idel_request_type make_request(logic [2:0] kind,
                                                     logic signed [VALUE_W-1:0] value,
                                                     logic [POS_W-1:0] pos);
      idel_request_type r;
      r.req_type   = kind;
      r.item_value = value;
      r.position   = pos;
      return r;
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_value();
      case ($urandom_range(0, 11))
         0:       return MIN_VALUE;
         1:       return MAX_VALUE;
         2:       return '1;
         3:       return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [POS_W-1:0] random_position();
      int unsigned n;
      n = board.held_count;
      case ($urandom_range(0, 7)) inside
         0:       return '1;
         1, 2:    return POS_W'($urandom_range(0, 255));
         3:       return POS_W'(n);
         default: return (n == 0) ? '0 : POS_W'($urandom_range(0, n - 1));
      endcase
   endfunction

   function automatic idel_request_type random_request(list_mix_type mix);
      int unsigned roll;
      int unsigned ins_share;
      logic [2:0]  kind;
      ins_share = (mix == FILL_UP) ? 65 : (mix == DRAIN) ? 20 : 42;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
         kind = 3'($urandom_range(6, 7));
      end else if (roll < 3 + ins_share) begin
         kind = $urandom_range(0, 1) ? REQ_INS_HEAD : REQ_INS_TAIL;
      end else begin
         case ($urandom_range(0, 3))
            0:       kind = REQ_DEL_POS;
            1:       kind = REQ_DEL_HEAD;
            2:       kind = REQ_DEL_TAIL;
            default: kind = REQ_READ;
         endcase
      end
      return make_request(kind, random_value(), random_position());
   endfunction

   // holds the request until the transfer edge, then records it
   task automatic send_request(idel_request_type r);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy !== 1'b0);
      board.note_request(r);
   endtask

   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clock);
   endtask

   initial begin
      list_mix_type mix;
      int unsigned  idle_odds;
      mix       = CHURN;
      idle_odds = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty list corners
      send_request(make_request(REQ_DEL_HEAD, '0, '0));
      send_request(make_request(REQ_DEL_TAIL, '1, '1));
      send_request(make_request(REQ_READ, '0, '0));
      send_request(make_request(REQ_DEL_POS, '0, '1));
      // extreme values at both ends
      send_request(make_request(REQ_INS_TAIL, MAX_VALUE, '0));
      send_request(make_request(REQ_INS_HEAD, MIN_VALUE, '1));
      send_request(make_request(REQ_INS_TAIL, '1, '0));
      send_request(make_request(REQ_INS_HEAD, '0, '0));
      send_request(make_request(REQ_READ, '0, 8'd0));
      send_request(make_request(REQ_READ, '0, 8'd3));
      send_request(make_request(REQ_READ, '0, 8'd4));
      send_request(make_request(REQ_READ, '0, '1));
      send_request(make_request(3'd6, '1, '1));
      send_request(make_request(3'd7, MIN_VALUE, 8'h5a));
      send_request(make_request(REQ_DEL_POS, '0, 8'd1));
      send_request(make_request(REQ_DEL_POS, '0, 8'd3));
      send_request(make_request(REQ_DEL_POS, '0, 8'd2));
      send_request(make_request(REQ_DEL_HEAD, '0, '0));
      // last entry leaves by the tail, then by the head
      send_request(make_request(REQ_DEL_TAIL, '0, '0));
      send_request(make_request(REQ_DEL_POS, '0, '0));
      send_request(make_request(REQ_INS_HEAD, 32'sh5555_aaaa, '0));
      send_request(make_request(REQ_DEL_HEAD, '0, '0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % MIX_SPAN == 0) begin
            case ($urandom_range(0, 2))
               0:       mix = FILL_UP;
               1:       mix = DRAIN;
               default: mix = CHURN;
            endcase
            case ($urandom_range(0, 2))
               0:       idle_odds = 0;
               1:       idle_odds = 8;
               default: idle_odds = 3;
            endcase
         end
         // no idling in the closing stretch
         if (n < RANDOM_ITEMS - QUIET_ITEMS && idle_odds != 0 &&
             $urandom_range(1, idle_odds) == 1) idle_burst();
         send_request(random_request(mix));
      end
      start <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);

      $display("covered %0d requests, %0d responses checked", board.requests_seen,
               board.responses_checked);
      $display("inserts into a full list %0d, out-of-range positions %0d, empty removals %0d",
               board.full_rejects, board.bad_positions, board.empty_removes);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
